// ----- src/linear_predicted_bitpack_table_assert.svh -----
// assertion macros for the packed table
`ifndef LINEAR_PREDICTED_BITPACK_TABLE_ASSERT_SVH
`define LINEAR_PREDICTED_BITPACK_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LPBT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lpbt assertion failed");
`define LPBT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("lpbt assertion failed");
`else
`define LPBT_ASSERT(lbl, clk, rstn, prop)
`define LPBT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/lpbt_pkg.sv -----
// shared constants, types and helpers for the packed table
`timescale 1ns / 1ps
package lpbt_pkg;
    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int WORD_BITS = 64;
    localparam int FRAC_BITS = 16;
    localparam int BITS_W = 7;
    localparam int FUNC_W = 2;
    localparam int STATUS_W = 2;
    localparam int DVD_W = WORD_BITS + FRAC_BITS;
    localparam int PROD_W = IDX_W + WORD_BITS;
    localparam int DCNT_W = $clog2(DVD_W);
    localparam int OFF_W = $clog2(WORD_BITS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_FREEZE = 2'd1,
        FUNC_GET    = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_PHASE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_F_INIT, S_BL1, S_RD0, S_RD1, S_RD2, S_DIV, S_DIV_END,
        S_DV_A, S_DV_B, S_DV_END, S_BL2, S_PACK_START, S_PK_A, S_PK_B,
        S_PK_END, S_G_A, S_G_B, S_G_C, S_G_D, S_R_A, S_R_B, S_DONE
    } state_t;

    function automatic logic [WORD_BITS-1:0] low_mask(input logic [BITS_W-1:0] bits);
        logic [WORD_BITS-1:0] m;
        if (bits >= BITS_W'(WORD_BITS)) begin
            m = '1;
        end else begin
            m = (WORD_BITS'(1) << bits) - WORD_BITS'(1);
        end
        return m;
    endfunction
endpackage

// ----- src/linear_predicted_bitpack_table.sv -----
// packed integer table with frame-of-reference coding and linear prediction
//
// channel  | handshake           | payload
// input    | s_valid / s_ready   | s_func, s_value, s_index
// result   | m_valid / m_ready   | m_status, m_result_value, m_entry_bits,
//          |                     | m_base_offset, m_slope_fixed, m_word_count
//
// get is paced by the shared 10x64 multiplier and the one read port of the packed store.
// freeze: up to two bit-length scans, the 80-step serial divider and two passes over the entries.
// s_ready is high only while idle; a pending result holds only the last step.
// reset (aresetn low, synchronous) clears control state; stores are not cleared.
`timescale 1ns / 1ps
`include "linear_predicted_bitpack_table_assert.svh"
module linear_predicted_bitpack_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lpbt_pkg::FUNC_W-1:0]       s_func,
    input  logic [lpbt_pkg::WORD_BITS-1:0]    s_value,
    input  logic [lpbt_pkg::IDX_W-1:0]        s_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lpbt_pkg::STATUS_W-1:0]     m_status,
    output logic [lpbt_pkg::WORD_BITS-1:0]    m_result_value,
    output logic [lpbt_pkg::BITS_W-1:0]       m_entry_bits,
    output logic [lpbt_pkg::WORD_BITS-1:0]    m_base_offset,
    output logic [lpbt_pkg::WORD_BITS-1:0]    m_slope_fixed,
    output logic [lpbt_pkg::CNT_W-1:0]        m_word_count
);
    import lpbt_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] min_reg, min_next;
    logic [WORD_BITS-1:0] max_reg, max_next;
    logic                 mono_reg, mono_next;
    logic                 frozen_reg, frozen_next;
    logic [WORD_BITS-1:0] offset_reg, offset_next;
    logic [BITS_W-1:0]    bits_reg, bits_next;
    logic [WORD_BITS-1:0] slope_reg, slope_next;
    logic [CNT_W-1:0]     wc_reg, wc_next;
    logic                 m_valid_reg, m_valid_next;

    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [WORD_BITS-1:0] first_reg, first_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [IDX_W-1:0]     rem_reg, rem_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [WORD_BITS-1:0] sc_reg, sc_next;
    logic [WORD_BITS-1:0] neg_reg, neg_next;
    logic [WORD_BITS-1:0] pos_reg, pos_next;
    logic [WORD_BITS-1:0] bl_v_reg, bl_v_next;
    logic [BITS_W-1:0]    bl_n_reg, bl_n_next;
    logic [WORD_BITS-1:0] cur_reg, cur_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [CNT_W-1:0]     widx_reg, widx_next;
    logic [WORD_BITS-1:0] w0_reg, w0_next;
    logic [OFF_W-1:0]     goff_reg, goff_next;
    logic [IDX_W-1:0]     gwi_reg, gwi_next;
    status_t              res_st_reg, res_st_next;
    logic [WORD_BITS-1:0] res_val_reg, res_val_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    status_t              m_status_reg, m_status_next;
    logic [WORD_BITS-1:0] m_result_reg, m_result_next;
    logic [BITS_W-1:0]    m_bits_reg, m_bits_next;
    logic [WORD_BITS-1:0] m_offset_reg, m_offset_next;
    logic [WORD_BITS-1:0] m_slope_reg, m_slope_next;
    logic [CNT_W-1:0]     m_wc_reg, m_wc_next;

    logic [IDX_W-1:0]     mul_a;
    logic [WORD_BITS-1:0] mul_b;
    logic                 v_we, p_we;
    logic [IDX_W-1:0]     v_waddr, v_raddr, p_waddr, p_raddr;
    logic [WORD_BITS-1:0] v_wdata, v_rdata, p_wdata, p_rdata;

    logic [CNT_W-1:0]     rem_sh, divisor;
    logic                 qbit;
    logic [WORD_BITS-1:0] pred, pval, resid, shifted, merged, raw;
    logic [BITS_W-1:0]    total;
    logic [WORD_BITS:0]   sum_w;
    logic                 spill;

    lpbt_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_ENTRIES)) u_value_ram (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    lpbt_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_ENTRIES)) u_packed_ram (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_result_reg;
    assign m_entry_bits   = m_bits_reg;
    assign m_base_offset  = m_offset_reg;
    assign m_slope_fixed  = m_slope_reg;
    assign m_word_count   = m_wc_reg;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign pred      = WORD_BITS'(prod_reg[PROD_W-1:FRAC_BITS]);
    assign divisor   = cnt_reg - CNT_W'(1);
    assign rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit      = (rem_sh >= divisor);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            min_reg     <= '1;
            max_reg     <= '0;
            mono_reg    <= 1'b1;
            frozen_reg  <= 1'b0;
            offset_reg  <= '0;
            bits_reg    <= '0;
            slope_reg   <= '0;
            wc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            mono_reg    <= mono_next;
            frozen_reg  <= frozen_next;
            offset_reg  <= offset_next;
            bits_reg    <= bits_next;
            slope_reg   <= slope_next;
            wc_reg      <= wc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        i_reg        <= i_next;
        first_reg    <= first_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        sc_reg       <= sc_next;
        neg_reg      <= neg_next;
        pos_reg      <= pos_next;
        bl_v_reg     <= bl_v_next;
        bl_n_reg     <= bl_n_next;
        cur_reg      <= cur_next;
        off_reg      <= off_next;
        widx_reg     <= widx_next;
        w0_reg       <= w0_next;
        goff_reg     <= goff_next;
        gwi_reg      <= gwi_next;
        res_st_reg   <= res_st_next;
        res_val_reg  <= res_val_next;
        prod_reg     <= prod_next;
        m_status_reg <= m_status_next;
        m_result_reg <= m_result_next;
        m_bits_reg   <= m_bits_next;
        m_offset_reg <= m_offset_next;
        m_slope_reg  <= m_slope_next;
        m_wc_reg     <= m_wc_next;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        mono_next     = mono_reg;
        frozen_next   = frozen_reg;
        offset_next   = offset_reg;
        bits_next     = bits_reg;
        slope_next    = slope_reg;
        wc_next       = wc_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        idx_next      = idx_reg;
        i_next        = i_reg;
        first_next    = first_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        sc_next       = sc_reg;
        neg_next      = neg_reg;
        pos_next      = pos_reg;
        bl_v_next     = bl_v_reg;
        bl_n_next     = bl_n_reg;
        cur_next      = cur_reg;
        off_next      = off_reg;
        widx_next     = widx_reg;
        w0_next       = w0_reg;
        goff_next     = goff_reg;
        gwi_next      = gwi_reg;
        res_st_next   = res_st_reg;
        res_val_next  = res_val_reg;
        m_status_next = m_status_reg;
        m_result_next = m_result_reg;
        m_bits_next   = m_bits_reg;
        m_offset_next = m_offset_reg;
        m_slope_next  = m_slope_reg;
        m_wc_next     = m_wc_reg;
        mul_a         = i_reg[IDX_W-1:0];
        mul_b         = sc_reg;
        v_we          = 1'b0;
        v_waddr       = cnt_reg[IDX_W-1:0];
        v_wdata       = s_value;
        v_raddr       = i_reg[IDX_W-1:0];
        p_we          = 1'b0;
        p_waddr       = widx_reg[IDX_W-1:0];
        p_wdata       = cur_reg;
        p_raddr       = idx_reg;
        pval          = min_reg + pred;
        resid         = (v_rdata - (offset_reg + pred)) & low_mask(bits_reg);
        shifted       = resid << off_reg;
        merged        = cur_reg | shifted;
        total         = BITS_W'(off_reg) + bits_reg;
        sum_w         = {1'b0, neg_reg} + {1'b0, pos_reg};
        spill         = (goff_reg != '0) && ((BITS_W'(goff_reg) + bits_reg) > BITS_W'(WORD_BITS));
        raw           = w0_reg >> goff_reg;
        if (spill) begin
            raw = raw | (p_rdata << (BITS_W'(WORD_BITS) - BITS_W'(goff_reg)));
        end
        raw = raw & low_mask(bits_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    idx_next     = s_index;
                    res_val_next = '0;
                    res_st_next  = ST_OK;
                    state_next   = S_DONE;
                    unique case (func_t'(s_func))
                        FUNC_ADD: begin
                            if (frozen_reg) begin
                                res_st_next = ST_PHASE;
                            end else if (cnt_reg == CNT_W'(MAX_ENTRIES)) begin
                                res_st_next = ST_FULL;
                            end else begin
                                v_we         = 1'b1;
                                res_val_next = WORD_BITS'(cnt_reg);
                                cnt_next     = cnt_reg + CNT_W'(1);
                                mono_next    = mono_reg && (s_value >= max_reg);
                                if (s_value < min_reg) begin
                                    min_next = s_value;
                                end
                                if (s_value > max_reg) begin
                                    max_next = s_value;
                                end
                            end
                        end
                        FUNC_FREEZE: begin
                            if (frozen_reg) begin
                                res_st_next = ST_PHASE;
                            end else begin
                                state_next = S_F_INIT;
                            end
                        end
                        FUNC_GET: begin
                            if (!frozen_reg) begin
                                res_st_next = ST_PHASE;
                            end else if (CNT_W'(s_index) >= cnt_reg) begin
                                res_st_next = ST_RANGE;
                            end else begin
                                state_next = S_G_A;
                            end
                        end
                        FUNC_READ: begin
                            if (!frozen_reg) begin
                                res_st_next = ST_PHASE;
                            end else if (CNT_W'(s_index) >= wc_reg) begin
                                res_st_next = ST_RANGE;
                            end else begin
                                state_next = S_R_A;
                            end
                        end
                        default: res_st_next = ST_PHASE;
                    endcase
                end
            end
            S_F_INIT: begin
                slope_next = '0;
                if (cnt_reg == '0) begin
                    offset_next = '0;
                    bits_next   = '0;
                    state_next  = S_PACK_START;
                end else begin
                    offset_next = min_reg;
                    bl_v_next   = max_reg - min_reg;
                    bl_n_next   = '0;
                    state_next  = S_BL1;
                end
            end
            S_BL1: begin
                if (bl_v_reg != '0) begin
                    bl_v_next = bl_v_reg >> 1;
                    bl_n_next = bl_n_reg + BITS_W'(1);
                end else begin
                    bits_next = bl_n_reg;
                    if (cnt_reg > CNT_W'(1) && mono_reg) begin
                        state_next = S_RD0;
                    end else begin
                        state_next = S_PACK_START;
                    end
                end
            end
            S_RD0: begin
                v_raddr    = '0;
                state_next = S_RD1;
            end
            S_RD1: begin
                v_raddr    = divisor[IDX_W-1:0];
                first_next = v_rdata;
                state_next = S_RD2;
            end
            S_RD2: begin
                dvd_next   = {v_rdata - first_reg, FRAC_BITS'(0)};
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next  = qbit ? IDX_W'(rem_sh - divisor) : rem_sh[IDX_W-1:0];
                dvd_next  = {dvd_reg[DVD_W-2:0], qbit};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DVD_W - 1)) begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END: begin
                if (dvd_reg[DVD_W-1:WORD_BITS] != '0) begin
                    state_next = S_PACK_START;
                end else begin
                    sc_next    = dvd_reg[WORD_BITS-1:0];
                    neg_next   = '0;
                    pos_next   = '0;
                    i_next     = CNT_W'(1);
                    state_next = S_DV_A;
                end
            end
            S_DV_A: begin
                state_next = S_DV_B;
            end
            S_DV_B: begin
                if (pval < v_rdata) begin
                    if (v_rdata - pval > pos_reg) begin
                        pos_next = v_rdata - pval;
                    end
                end else if (pval - v_rdata > neg_reg) begin
                    neg_next = pval - v_rdata;
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = (i_next == cnt_reg) ? S_DV_END : S_DV_A;
            end
            S_DV_END: begin
                if (!sum_w[WORD_BITS] && (sum_w[WORD_BITS-1:0] != '1)) begin
                    bl_v_next  = sum_w[WORD_BITS-1:0] + WORD_BITS'(1);
                    bl_n_next  = '0;
                    state_next = S_BL2;
                end else begin
                    state_next = S_PACK_START;
                end
            end
            S_BL2: begin
                if (bl_v_reg != '0) begin
                    bl_v_next = bl_v_reg >> 1;
                    bl_n_next = bl_n_reg + BITS_W'(1);
                end else begin
                    if (bl_n_reg < bits_reg) begin
                        offset_next = min_reg - neg_reg;
                        bits_next   = bl_n_reg;
                        slope_next  = sc_reg;
                    end
                    state_next = S_PACK_START;
                end
            end
            S_PACK_START: begin
                frozen_next = 1'b1;
                if (bits_reg == '0) begin
                    wc_next    = '0;
                    state_next = S_DONE;
                end else begin
                    i_next     = '0;
                    off_next   = '0;
                    cur_next   = '0;
                    widx_next  = '0;
                    state_next = S_PK_A;
                end
            end
            S_PK_A: begin
                mul_b      = slope_reg;
                state_next = S_PK_B;
            end
            S_PK_B: begin
                if (total >= BITS_W'(WORD_BITS)) begin
                    p_we      = 1'b1;
                    p_wdata   = merged;
                    widx_next = widx_reg + CNT_W'(1);
                    if (off_reg == '0) begin
                        cur_next = '0;
                    end else begin
                        cur_next = resid >> (BITS_W'(WORD_BITS) - BITS_W'(off_reg));
                    end
                end else begin
                    cur_next = merged;
                end
                off_next   = total[OFF_W-1:0];
                i_next     = i_reg + CNT_W'(1);
                state_next = (i_next == cnt_reg) ? S_PK_END : S_PK_A;
            end
            S_PK_END: begin
                if (off_reg != '0) begin
                    p_we    = 1'b1;
                    wc_next = widx_reg + CNT_W'(1);
                end else begin
                    wc_next = widx_reg;
                end
                state_next = S_DONE;
            end
            S_G_A: begin
                mul_a      = idx_reg;
                mul_b      = WORD_BITS'(bits_reg);
                state_next = S_G_B;
            end
            S_G_B: begin
                goff_next  = prod_reg[OFF_W-1:0];
                gwi_next   = prod_reg[OFF_W+IDX_W-1:OFF_W];
                p_raddr    = prod_reg[OFF_W+IDX_W-1:OFF_W];
                state_next = S_G_C;
            end
            S_G_C: begin
                p_raddr    = gwi_reg + IDX_W'(1);
                w0_next    = p_rdata;
                mul_a      = idx_reg;
                mul_b      = slope_reg;
                state_next = S_G_D;
            end
            S_G_D: begin
                res_val_next = raw + offset_reg + pred;
                state_next   = S_DONE;
            end
            S_R_A: begin
                state_next = S_R_B;
            end
            S_R_B: begin
                res_val_next = p_rdata;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_st_reg;
                    m_result_next = res_val_reg;
                    m_bits_next   = bits_reg;
                    m_offset_next = offset_reg;
                    m_slope_next  = slope_reg;
                    m_wc_next     = wc_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `LPBT_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `LPBT_ASSERT(a_frozen_sticks, aclk, aresetn, frozen_reg |=> frozen_reg)
    `LPBT_ASSERT(a_bits_range, aclk, aresetn, bits_reg <= BITS_W'(WORD_BITS))
    `LPBT_ASSERT(a_no_words_unfrozen, aclk, aresetn, !frozen_reg |-> (wc_reg == '0))
    `LPBT_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_valid_reg)
endmodule

// ----- src/lpbt_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lpbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
